[rtl/core/aip_pkg.sv]
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and codes of the ASCII integer parser: configuration,
// parse state, phase codes, radix codes and register indexes.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned MAXW_BITS      = 16;
  localparam int unsigned ADDR_BITS      = 4;

  // register indexes, byte address 4*index
  localparam logic [1:0] REG_RADIX  = 2'd0;
  localparam logic [1:0] REG_SIGNED = 2'd1;
  localparam logic [1:0] REG_BINPFX = 2'd2;
  localparam logic [1:0] REG_MAXW   = 2'd3;

  // radix_select codes
  localparam logic [2:0] SEL_AUTO = 3'd0;
  localparam logic [2:0] SEL_BIN  = 3'd1;
  localparam logic [2:0] SEL_OCT  = 3'd2;
  localparam logic [2:0] SEL_DEC  = 3'd3;
  localparam logic [2:0] SEL_HEX  = 3'd4;

  // working radix values, zero stands for automatic selection
  localparam logic [4:0] RADIX_AUTO = 5'd0;
  localparam logic [4:0] RADIX_BIN  = 5'd2;
  localparam logic [4:0] RADIX_OCT  = 5'd8;
  localparam logic [4:0] RADIX_DEC  = 5'd10;
  localparam logic [4:0] RADIX_HEX  = 5'd16;

  // parse phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_XSEEN  = 3'd3;
  localparam logic [2:0] PH_BSEEN  = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  typedef struct packed {
    logic [2:0]           radix_sel;
    logic                 signed_res;
    logic                 bin_en;
    logic [MAXW_BITS-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        ovf;
    logic        neg;
    logic [2:0]  phase;
    logic [4:0]  radix;
  } parse_t;

endpackage

[rtl/core/aip_step.sv]
// ----------------------------------------------------------------------------
// aip_step
// One parse step: takes the current state and one character, gives the
// next state and whether a number ends on this character.
// ----------------------------------------------------------------------------
module aip_step #(
  parameter int unsigned COUNT_BITS = aip_pkg::COUNT_BITS_DEF
) (
  input  aip_pkg::cfg_t          cfg_i,
  input  aip_pkg::parse_t        state_i,
  input  logic [COUNT_BITS-1:0]  count_i,
  input  logic [COUNT_BITS-1:0]  dstart_i,
  input  logic [7:0]             char_i,
  input  logic                   first_i,
  output aip_pkg::parse_t        state_o,
  output logic [COUNT_BITS-1:0]  count_o,
  output logic [COUNT_BITS-1:0]  dstart_o,
  output logic                   emit_o
);
  import aip_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > MAXW_BITS) ? COUNT_BITS : MAXW_BITS;
  localparam int unsigned LW = CW + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [6:0] NOT_DIGIT = 7'd99;
  localparam logic [6:0] DIG_B     = 7'd11;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [6:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 7'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = 7'(c - CH_LA) + 7'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = 7'(c - CH_UA) + 7'd10;
    end else begin
      d = NOT_DIGIT;
    end
    return d;
  endfunction

  function automatic logic [4:0] sel_radix(input logic [2:0] rs);
    logic [4:0] r;
    unique case (rs)
      SEL_BIN: r = RADIX_BIN;
      SEL_OCT: r = RADIX_OCT;
      SEL_DEC: r = RADIX_DEC;
      SEL_HEX: r = RADIX_HEX;
      default: r = RADIX_AUTO;
    endcase
    return r;
  endfunction

  // accumulator times radix as shifts, with one add for decimal, four spare top bits
  function automatic logic [67:0] mul_radix(input logic [63:0] a, input logic [4:0] r);
    logic [67:0] w;
    logic [67:0] p;
    w = {4'b0, a};
    unique case (r)
      RADIX_BIN: p = w << 1;
      RADIX_OCT: p = w << 3;
      RADIX_DEC: p = (w << 3) + (w << 1);
      default:   p = w << 4;
    endcase
    return p;
  endfunction

  function automatic logic at_limit(input logic [COUNT_BITS-1:0] cnt,
                                    input logic [MAXW_BITS-1:0]  mw);
    return (mw != '0) && (LW'(cnt) >= LW'(mw));
  endfunction

  function automatic logic room(input logic [COUNT_BITS-1:0] cnt,
                                input logic [MAXW_BITS-1:0]  mw);
    return (mw == '0) || ((LW'(cnt) + LW'(2)) < LW'(mw));
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump1(input logic [COUNT_BITS-1:0] cnt);
    return (cnt == CNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump2(input logic [COUNT_BITS-1:0] cnt);
    return (cnt >= CNT_MAX - COUNT_BITS'(1)) ? CNT_MAX : cnt + COUNT_BITS'(2);
  endfunction

  logic [6:0]            dig;
  logic [6:0]            ldig;
  logic [4:0]            srad;
  logic [4:0]            rrad;
  logic [4:0]            lrad;
  logic                  hex_c;
  logic                  bin_c;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [2:0]            phase_eff;
  logic                  use_feed;
  logic                  use_rep;
  logic                  rep_letter;
  logic [63:0]           f_acc;
  logic [COUNT_BITS-1:0] f_cnt;
  logic [4:0]            f_rad;
  logic [6:0]            f_dig;
  logic [67:0]           f_prod;
  logic [COUNT_BITS-1:0] r_cnt;
  logic [8:0]            r_acc;
  logic                  r_done;

  assign dig       = digit_of(char_i);
  assign srad      = sel_radix(cfg_i.radix_sel);
  assign rrad      = (srad == RADIX_AUTO) ? RADIX_OCT : srad;
  assign base_cnt  = first_i ? '0 : count_i;
  assign phase_eff = first_i ? PH_PREFIX : state_i.phase;
  assign hex_c     = ((srad == RADIX_AUTO) || (srad == RADIX_HEX)) &&
                     room(base_cnt, cfg_i.max_width);
  assign bin_c     = cfg_i.bin_en && ((srad == RADIX_AUTO) || (srad == RADIX_BIN)) &&
                     room(base_cnt, cfg_i.max_width);

  always_comb begin
    state_o    = state_i;
    count_o    = count_i;
    dstart_o   = dstart_i;
    emit_o     = 1'b0;
    use_feed   = 1'b0;
    use_rep    = 1'b0;
    rep_letter = 1'b0;
    ldig       = NOT_DIGIT;
    lrad       = RADIX_HEX;
    f_acc      = state_i.acc;
    f_cnt      = count_i;
    f_rad      = state_i.radix;
    f_dig      = dig;
    f_prod     = '0;
    r_cnt      = count_i;
    r_acc      = '0;
    r_done     = 1'b0;

    // a new number drops whatever was in progress
    if (first_i) begin
      state_o.acc   = '0;
      state_o.ovf   = 1'b0;
      state_o.neg   = 1'b0;
      state_o.radix = RADIX_DEC;
      state_o.phase = PH_PREFIX;
      count_o       = '0;
      dstart_o      = '0;
      f_acc         = '0;
      f_cnt         = '0;
    end

    if (first_i && (char_i == CH_PLUS || char_i == CH_MINUS)) begin
      state_o.neg = (char_i == CH_MINUS);
      count_o     = bump1('0);
      dstart_o    = count_o;
      emit_o      = at_limit(count_o, cfg_i.max_width);
    end else begin
      unique case (phase_eff)
        PH_PREFIX: begin
          if (char_i == CH_ZERO && (hex_c || bin_c)) begin
            state_o.phase = PH_ZERO;
          end else begin
            if (srad == RADIX_AUTO) begin
              f_rad = (char_i == CH_ZERO) ? RADIX_OCT : RADIX_DEC;
            end else begin
              f_rad = srad;
            end
            state_o.radix = f_rad;
            state_o.phase = PH_DIGITS;
            dstart_o      = base_cnt;
            f_cnt         = base_cnt;
            use_feed      = 1'b1;
          end
        end
        PH_ZERO: begin
          if ((char_i == CH_LX || char_i == CH_UX) && hex_c) begin
            state_o.phase = PH_XSEEN;
          end else if ((char_i == CH_LB || char_i == CH_UB) && bin_c) begin
            state_o.phase = PH_BSEEN;
          end else begin
            use_rep = 1'b1;
          end
        end
        PH_XSEEN, PH_BSEEN: begin
          lrad = (state_i.phase == PH_XSEEN) ? RADIX_HEX : RADIX_BIN;
          if (dig < 7'(lrad)) begin
            f_cnt         = bump2(count_i);
            f_rad         = lrad;
            state_o.radix = lrad;
            state_o.phase = PH_DIGITS;
            dstart_o      = f_cnt;
            use_feed      = 1'b1;
          end else begin
            use_rep    = 1'b1;
            rep_letter = 1'b1;
            ldig       = (state_i.phase == PH_XSEEN) ? NOT_DIGIT : DIG_B;
          end
        end
        PH_DIGITS: use_feed = 1'b1;
        default: ;
      endcase
    end

    if (use_feed) begin
      count_o = f_cnt;
      if (at_limit(f_cnt, cfg_i.max_width) || (f_dig >= 7'(f_rad))) begin
        emit_o = 1'b1;
      end else begin
        f_prod = mul_radix(f_acc, f_rad) + 68'(f_dig);
        // on overflow keep the old accumulator, only flag it
        if (f_prod[67:64] != 4'b0) begin
          state_o.ovf = 1'b1;
        end else begin
          state_o.acc = f_prod[63:0];
        end
        count_o = bump1(f_cnt);
        emit_o  = at_limit(count_o, cfg_i.max_width);
      end
    end

    // no prefix after all: take the held zero, the held letter, then this
    // character. Accumulator is still zero in every prefix phase.
    if (use_rep) begin
      state_o.radix = rrad;
      state_o.phase = PH_DIGITS;
      dstart_o      = count_i;
      if (at_limit(r_cnt, cfg_i.max_width)) begin
        r_done = 1'b1;
      end else begin
        r_cnt  = bump1(r_cnt);
        r_done = at_limit(r_cnt, cfg_i.max_width);
      end
      if (!r_done && rep_letter) begin
        if (ldig >= 7'(rrad)) begin
          r_done = 1'b1;
        end else begin
          r_acc  = 9'(ldig);
          r_cnt  = bump1(r_cnt);
          r_done = at_limit(r_cnt, cfg_i.max_width);
        end
      end
      if (!r_done) begin
        if (dig >= 7'(rrad)) begin
          r_done = 1'b1;
        end else begin
          r_acc  = 9'(r_acc * 9'(rrad)) + 9'(dig);
          r_cnt  = bump1(r_cnt);
          r_done = at_limit(r_cnt, cfg_i.max_width);
        end
      end
      state_o.acc = 64'(r_acc);
      count_o     = r_cnt;
      emit_o      = r_done;
    end

    if (emit_o) begin
      state_o.phase = PH_IDLE;
    end
  end

endmodule

[rtl/core/ascii_integer_parser.sv]
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Parses one ASCII integer per number from a byte stream, strtoull style.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one character per
//   transaction; first_i marks the first byte of a new number. Output channel
//   (out_valid_o / out_ready_i) carries one result per finished number: value,
//   bytes consumed, match flag and saturation flag.
//   A number ends on the first byte that is not accepted as part of it, or on
//   the byte that reaches max_width; a byte with first_i low while idle is
//   dropped.
//   A result is offered from the result register once the transaction that
//   ends the number has passed the input register. Throughput: one
//   character per cycle while the result register is free or being read, set
//   by the combinational accumulate step (shift-add by the radix with its overflow check).
//   When the receiver stalls with a result waiting, the input register holds
//   and in_ready_o stays high only while that register is empty.
//   Reset clears parse state and the pipeline; registers come up as automatic
//   radix, signed clamp, binary prefix off, unlimited width.
//   Registers via the APB port at byte addresses 0, 4, 8, 12: radix_select,
//   signed_result, binary_prefix_enable, max_width. Write only between numbers
//   or with no transaction in flight.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
  parameter int unsigned COUNT_BITS = aip_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aip_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   char_byte_i,
  input  logic                         first_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [63:0]                  value_o,
  output logic [15:0]                  consumed_o,
  output logic                         matched_o,
  output logic                         saturated_o
);
  import aip_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [15:0] CONS_MAX = 16'hFFFF;
  localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;

  cfg_t cfg_q;

  logic                  in_valid_q;
  logic [7:0]            in_char_q;
  logic                  in_first_q;
  logic                  out_free;
  logic                  advance;

  parse_t                st_q;
  parse_t                st_d;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [COUNT_BITS-1:0] cnt_d;
  logic [COUNT_BITS-1:0] ds_q;
  logic [COUNT_BITS-1:0] ds_d;
  logic                  emit;

  logic                  out_valid_q;
  logic [63:0]           out_acc_q;
  logic                  out_ovf_q;
  logic                  out_neg_q;
  logic                  out_ok_q;
  logic                  out_signed_q;
  logic [15:0]           out_cons_q;
  logic                  ok_d;
  logic [CW-1:0]         cnt_w;
  logic [15:0]           cons_d;
  logic [63:0]           lim;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix_sel  <= SEL_AUTO;
      cfg_q.signed_res <= 1'b1;
      cfg_q.bin_en     <= 1'b0;
      cfg_q.max_width  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_RADIX:  cfg_q.radix_sel  <= pwdata[2:0];
        REG_SIGNED: cfg_q.signed_res <= pwdata[0];
        REG_BINPFX: cfg_q.bin_en     <= pwdata[0];
        REG_MAXW:   cfg_q.max_width  <= pwdata[MAXW_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIX:  prdata = {29'b0, cfg_q.radix_sel};
      REG_SIGNED: prdata = {31'b0, cfg_q.signed_res};
      REG_BINPFX: prdata = {31'b0, cfg_q.bin_en};
      REG_MAXW:   prdata = {16'b0, cfg_q.max_width};
    endcase
  end

  // input register
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q  <= char_byte_i;
      in_first_q <= first_i;
    end
  end

  aip_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .count_i  (cnt_q),
    .dstart_i (ds_q),
    .char_i   (in_char_q),
    .first_i  (in_first_q),
    .state_o  (st_d),
    .count_o  (cnt_d),
    .dstart_o (ds_d),
    .emit_o   (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.acc   <= '0;
      st_q.ovf   <= 1'b0;
      st_q.neg   <= 1'b0;
      st_q.phase <= PH_IDLE;
      st_q.radix <= RADIX_DEC;
      cnt_q      <= '0;
      ds_q       <= '0;
    end else if (advance) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ds_q  <= ds_d;
    end
  end

  // result register, finish arithmetic sits after it
  assign ok_d   = (cnt_d != ds_d);
  assign cnt_w  = CW'(cnt_d);
  assign cons_d = !ok_d ? 16'b0 : ((cnt_w > CW'(CONS_MAX)) ? CONS_MAX : cnt_w[15:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_acc_q    <= st_d.acc;
      out_ovf_q    <= st_d.ovf;
      out_neg_q    <= st_d.neg;
      out_ok_q     <= ok_d;
      out_signed_q <= cfg_q.signed_res;
      out_cons_q   <= cons_d;
    end
  end

  assign lim = out_neg_q ? S64_MIN : S64_MAX;

  always_comb begin
    value_o     = out_acc_q;
    saturated_o = 1'b0;
    if (!out_ok_q) begin
      value_o = '0;
    end else if (out_signed_q) begin
      if (out_ovf_q || out_acc_q > lim) begin
        value_o     = lim;
        saturated_o = 1'b1;
      end else if (out_neg_q) begin
        value_o = 64'b0 - out_acc_q;
      end
    end else begin
      if (out_ovf_q) begin
        value_o     = '1;
        saturated_o = 1'b1;
      end else if (out_neg_q) begin
        value_o = 64'b0 - out_acc_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign consumed_o  = out_cons_q;
  assign matched_o   = out_ok_q;

  // prefix phases never carry digits yet
  a_prefix_acc_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_PREFIX || st_q.phase == PH_ZERO ||
     st_q.phase == PH_XSEEN || st_q.phase == PH_BSEEN) |-> (st_q.acc == '0 && !st_q.ovf))
    else $error("accumulator not clear before digits");

  a_dstart_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_q <= cnt_q)
    else $error("digit start beyond byte count");

  a_radix_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.radix == RADIX_BIN || st_q.radix == RADIX_OCT ||
     st_q.radix == RADIX_DEC || st_q.radix == RADIX_HEX))
    else $error("illegal working radix");

  a_stall_holds_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |=>
      ($stable(st_q) && $stable(cnt_q) && $stable(ds_q)))
    else $error("parse state moved during output stall");

endmodule

[sim/aip_parse_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aip_parse_checker
// Watches the register port and both streaming channels of the ASCII integer
// parser, predicts each parsed number from the accepted characters and the
// register settings, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module aip_parse_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [aip_pkg::ADDR_BITS-1:0] paddr_i,
  input  logic [31:0]                   pwdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [7:0]                    char_byte_i,
  input  logic                          first_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [63:0]                   value_i,
  input  logic [15:0]                   consumed_i,
  input  logic                          matched_i,
  input  logic                          saturated_i,
  output int unsigned                   results_due_o,
  output int unsigned                   mismatch_count_o
);
  import aip_pkg::*;

  localparam int unsigned CNT_SAT     = (1 << COUNT_BITS_DEF) - 1;
  localparam int unsigned NOT_A_DIGIT = 99;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] consumed;
    logic        matched;
    logic        saturated;
  } number_t;

  cfg_t        cfg;
  logic [63:0] acc;
  logic        ovf;
  logic        neg;
  logic [2:0]  phase;
  int unsigned cnt;
  int unsigned radix;
  int unsigned digits_start;
  number_t     produced;
  logic        produced_ok;
  number_t     numbers_due[$];
  int unsigned mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic int unsigned char_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return NOT_A_DIGIT;
  endfunction

  function automatic int unsigned selected_radix();
    case (cfg.radix_sel)
      SEL_BIN: return RADIX_BIN;
      SEL_OCT: return RADIX_OCT;
      SEL_DEC: return RADIX_DEC;
      SEL_HEX: return RADIX_HEX;
      default: return RADIX_AUTO;
    endcase
  endfunction

  function automatic logic width_reached();
    return cfg.max_width != 0 && cnt >= cfg.max_width;
  endfunction

  function automatic logic prefix_fits();
    return cfg.max_width == 0 || cnt + 2 < cfg.max_width;
  endfunction

  function automatic void count_bytes(input int unsigned n);
    cnt = (CNT_SAT - cnt < n) ? CNT_SAT : cnt + n;
  endfunction

  function automatic logic close_number();
    logic [63:0] v;
    logic [63:0] lim;
    logic        sat;
    logic        ok;
    v   = acc;
    sat = 1'b0;
    ok  = cnt != digits_start;
    if (!ok) begin
      v = '0;
    end else if (cfg.signed_res) begin
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (ovf || v > lim) begin
        v   = lim;
        sat = 1'b1;
      end else if (neg) begin
        v = -v;
      end
    end else if (ovf) begin
      v   = '1;
      sat = 1'b1;
    end else if (neg) begin
      // unsigned negatives wrap
      v = -v;
    end
    produced.value     = v;
    produced.consumed  = !ok ? 16'd0 : (cnt > 16'hFFFF ? 16'hFFFF : cnt[15:0]);
    produced.matched   = ok;
    produced.saturated = sat;
    produced_ok        = 1'b1;
    phase              = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic logic take_digit(input int unsigned d);
    logic [63:0] d64;
    logic [63:0] r64;
    d64 = d;
    r64 = radix;
    if (width_reached() || d >= radix) return close_number();
    if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d64) / r64) ovf = 1'b1;
    else acc = acc * r64 + d64;
    count_bytes(1);
    if (width_reached()) return close_number();
    return 1'b0;
  endfunction

  function automatic void start_digits(input int unsigned r);
    radix        = r;
    digits_start = cnt;
    phase        = PH_DIGITS;
  endfunction

  function automatic logic hex_prefix_ok();
    int unsigned s;
    s = selected_radix();
    return (s == RADIX_AUTO || s == RADIX_HEX) && prefix_fits();
  endfunction

  function automatic logic bin_prefix_ok();
    int unsigned s;
    s = selected_radix();
    return cfg.bin_en && (s == RADIX_AUTO || s == RADIX_BIN) && prefix_fits();
  endfunction

  function automatic logic lead_byte(input logic [7:0] c);
    int unsigned s;
    s = selected_radix();
    if (c == "0" && (hex_prefix_ok() || bin_prefix_ok())) begin
      phase = PH_ZERO;
      return 1'b0;
    end
    if (s == RADIX_AUTO) start_digits(c == "0" ? RADIX_OCT : RADIX_DEC);
    else start_digits(s);
    return take_digit(char_digit(c));
  endfunction

  // no prefix after all: feed the held zero, the held letter, then this byte
  function automatic logic replay_zero(input logic [7:0] letter, input logic have_letter,
                                       input logic [7:0] c);
    int unsigned s;
    s = selected_radix();
    start_digits(s == RADIX_AUTO ? RADIX_OCT : s);
    if (take_digit(0)) return 1'b1;
    if (have_letter && take_digit(char_digit(letter))) return 1'b1;
    return take_digit(char_digit(c));
  endfunction

  function automatic logic zero_byte(input logic [7:0] c);
    if ((c == "x" || c == "X") && hex_prefix_ok()) begin
      phase = PH_XSEEN;
      return 1'b0;
    end
    if ((c == "b" || c == "B") && bin_prefix_ok()) begin
      phase = PH_BSEEN;
      return 1'b0;
    end
    return replay_zero(8'h00, 1'b0, c);
  endfunction

  function automatic logic letter_byte(input int unsigned r, input logic [7:0] letter,
                                       input logic [7:0] c);
    int unsigned d;
    d = char_digit(c);
    if (d < r) begin
      count_bytes(2);
      start_digits(r);
      return take_digit(d);
    end
    return replay_zero(letter, 1'b1, c);
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic f);
    if (f) begin
      acc          = '0;
      ovf          = 1'b0;
      neg          = 1'b0;
      cnt          = 0;
      digits_start = 0;
      radix        = RADIX_DEC;
      phase        = PH_PREFIX;
      if (c == "+" || c == "-") begin
        neg = c == "-";
        count_bytes(1);
        digits_start = cnt;
        if (width_reached()) void'(close_number());
      end else begin
        void'(lead_byte(c));
      end
    end else begin
      case (phase)
        PH_PREFIX: void'(lead_byte(c));
        PH_ZERO:   void'(zero_byte(c));
        PH_XSEEN:  void'(letter_byte(RADIX_HEX, "x", c));
        PH_BSEEN:  void'(letter_byte(RADIX_BIN, "b", c));
        PH_DIGITS: void'(take_digit(char_digit(c)));
        default: ;  // drop bytes while idle
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result();
    number_t want;
    if (numbers_due.size() == 0) begin
      report_mismatch($sformatf("result with none due, value %0h", value_i));
      return;
    end
    want = numbers_due.pop_front();
    if (value_i !== want.value)
      report_mismatch($sformatf("value %0h, expected %0h", value_i, want.value));
    if (consumed_i !== want.consumed)
      report_mismatch($sformatf("consumed %0d, expected %0d", consumed_i, want.consumed));
    if (matched_i !== want.matched)
      report_mismatch($sformatf("matched %b, expected %b", matched_i, want.matched));
    if (saturated_i !== want.saturated)
      report_mismatch($sformatf("saturated %b, expected %b", saturated_i, want.saturated));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.radix_sel  = SEL_AUTO;
      cfg.signed_res = 1'b1;
      cfg.bin_en     = 1'b0;
      cfg.max_width  = '0;
      acc            = '0;
      ovf            = 1'b0;
      neg            = 1'b0;
      phase          = PH_IDLE;
      cnt            = 0;
      radix          = RADIX_DEC;
      digits_start   = 0;
      numbers_due.delete();
      results_due_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[aip_pkg::ADDR_BITS-1:2])
          REG_RADIX:  cfg.radix_sel  = pwdata_i[2:0];
          REG_SIGNED: cfg.signed_res = pwdata_i[0];
          REG_BINPFX: cfg.bin_en     = pwdata_i[0];
          REG_MAXW:   cfg.max_width  = pwdata_i[15:0];
          default: ;
        endcase
      end
      // compare before predicting, so a new prediction never meets an old result
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        produced_ok = 1'b0;
        parse_char(char_byte_i, first_i);
        if (produced_ok) numbers_due.push_back(produced);
      end
      results_due_o <= numbers_due.size();
    end
  end

endmodule

[sim/tb_ascii_integer_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser
// Drives characters and register writes into the ASCII integer parser:
// directed numbers for signs, prefixes, held prefix bytes, width limits and
// matching failures, two overflowing digit runs, then random numbers and noise
// under a range of register settings with random idling on both channels.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;
  import aip_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned IDLE_PERCENT    = 38;
  localparam int unsigned RUN_BYTES       = 24;
  localparam int unsigned CONFIG_PHASES   = 8;
  localparam int unsigned BYTES_PER_PHASE = 125;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [ADDR_BITS-1:0] paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           char_byte_i = '0;
  logic                 first_i     = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [63:0]          value_o;
  logic [15:0]          consumed_o;
  logic                 matched_o;
  logic                 saturated_o;

  int unsigned cycle_count = 0;
  logic        idle_on     = 1'b0;
  int unsigned hold_asked  = 0;
  int unsigned hold_given  = 0;
  int unsigned hold_left   = 0;
  int unsigned results_due;
  int unsigned mismatch_count;

  ascii_integer_parser dut (.*);

  aip_parse_checker parse_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .char_byte_i      (char_byte_i),
    .first_i          (first_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_i          (value_o),
    .consumed_i       (consumed_o),
    .matched_i        (matched_o),
    .saturated_i      (saturated_o),
    .results_due_o    (results_due),
    .mismatch_count_o (mismatch_count)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL ascii_integer_parser");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      hold_given  <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (idle_on) begin
      out_ready_i <= $urandom_range(99) >= IDLE_PERCENT;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic f);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    first_i     <= f;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  task automatic send_digit_run(input int unsigned n);
    logic [7:0] ch;
    for (int unsigned i = 0; i < n; i++) begin
      ch = 8'("0" + $urandom_range(9));
      send_char(ch, i == 0);
    end
  endtask

  // hold until every due result has come back and the pipeline has drained
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] sel, input logic sgn, input logic bin,
                            input logic [15:0] width);
    write_register(REG_RADIX, {29'd0, sel});
    write_register(REG_SIGNED, {31'd0, sgn});
    write_register(REG_BINPFX, {31'd0, bin});
    write_register(REG_MAXW, {16'd0, width});
  endtask

  // mostly well-formed numbers with random content, some noise bytes
  task automatic send_number(inout int unsigned sent);
    logic [7:0]  text[$];
    logic [7:0]  ch;
    int unsigned base;
    int unsigned len;
    int unsigned d;
    int unsigned roll;
    if ($urandom_range(99) < 15) begin
      send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      sent++;
      return;
    end
    case ($urandom_range(3))
      0: text.push_back("+");
      1: text.push_back("-");
      default: ;
    endcase
    case ($urandom_range(5))
      0: begin text.push_back("0"); text.push_back("x"); base = 16; end
      1: begin text.push_back("0"); text.push_back("X"); base = 16; end
      2: begin text.push_back("0"); text.push_back("b"); base = 2; end
      3: begin text.push_back("0"); text.push_back("B"); base = 2; end
      4: begin text.push_back("0"); base = 8; end
      default: begin
        case ($urandom_range(3))
          0: base = 2;
          1: base = 8;
          2: base = 10;
          default: base = 16;
        endcase
      end
    endcase
    roll = $urandom_range(99);
    if (roll < 5) len = 0;
    else if (roll < 15) len = $urandom_range(15, 24);  // long runs; the longest overflow in any radix but binary
    else len = $urandom_range(1, 6);
    for (int unsigned i = 0; i < len; i++) begin
      d = $urandom_range(base - 1);
      if (d < 10) ch = 8'("0" + d);
      else ch = 8'(($urandom_range(1) ? "a" : "A") + d - 10);
      text.push_back(ch);
    end
    case ($urandom_range(3))
      0: text.push_back(8'h00);
      1: text.push_back(8'($urandom_range(255)));
      2: text.push_back(" ");
      default: ;  // let the next number cut this one off
    endcase
    foreach (text[i]) send_char(text[i], i == 0);
    sent += text.size();
  endtask

  initial begin : stimulus
    int unsigned sent;
    logic [15:0] width;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed numbers under the reset settings
    send_char("5", 1'b0);
    send_text("-12");
    send_char(8'h00, 1'b0);
    send_text("0x1F,");
    send_text("0xg");
    send_text("0179");
    send_text("+");
    send_text("-z");
    send_char(8'hFF, 1'b1);

    wait_quiet();
    set_config(SEL_AUTO, 1'b0, 1'b1, 16'd4);
    send_text("-0b1");

    // lower the width while a number is open
    wait_quiet();
    set_config(SEL_DEC, 1'b1, 1'b0, 16'd0);
    send_text("123");
    wait_quiet();
    write_register(REG_MAXW, 32'd2);
    send_char("4", 1'b0);

    // widest limit, then no limit, each with a run long enough to overflow
    wait_quiet();
    set_config(SEL_DEC, 1'b1, 1'b0, 16'hFFFF);
    send_digit_run(RUN_BYTES);
    wait_quiet();
    write_register(REG_MAXW, 32'd0);
    send_digit_run(RUN_BYTES);
    send_char(8'h00, 1'b0);

    for (int unsigned p = 0; p < CONFIG_PHASES; p++) begin
      wait_quiet();
      case ($urandom_range(4))
        0: width = 16'd0;
        1: width = 16'($urandom_range(1, 4));
        2: width = 16'($urandom_range(5, 30));
        3: width = 16'hFFFF;
        default: width = 16'd2;
      endcase
      set_config(p[2:0], 1'($urandom_range(1)), 1'($urandom_range(1)), width);
      idle_on <= p >= 2;
      if (p == 4) hold_asked <= hold_asked + 1;
      sent = 0;
      while (sent < BYTES_PER_PHASE) send_number(sent);
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("PASS ascii_integer_parser");
    end else begin
      $display("FAIL ascii_integer_parser");
    end
    $finish;
  end

endmodule
